// File: src/vb128_pkg.sv
`default_nettype none

package vb128_pkg;

   localparam logic [7:0] PAYLOAD_MASK  = 8'h7f;
   localparam logic [7:0] CONT_BIT      = 8'h80;
   localparam logic [6:0] BITS_PER_BYTE = 7'd7;
   localparam int         ValueWidth    = 64;
   localparam int         IndexWidth    = 4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_last;
   } req_word_type;

   typedef struct packed {
      logic [ValueWidth-1:0] decoded_value;
      logic                  status;
   } rsp_word_type;

   // most bytes one value may span, 8*bytes/7+1
   function automatic logic [IndexWidth:0] byte_limit(input width_mode_type mode);
      logic [IndexWidth:0] lim;
      unique case (mode)
         WIDTH_8:  lim = 5'd2;
         WIDTH_16: lim = 5'd3;
         WIDTH_32: lim = 5'd5;
         WIDTH_64: lim = 5'd10;
         default:  lim = 5'd10;
      endcase
      return lim;
   endfunction

   function automatic logic [ValueWidth-1:0] width_mask(input width_mode_type mode);
      logic [ValueWidth-1:0] m;
      unique case (mode)
         WIDTH_8:  m = 64'h0000_0000_0000_00ff;
         WIDTH_16: m = 64'h0000_0000_0000_ffff;
         WIDTH_32: m = 64'h0000_0000_ffff_ffff;
         WIDTH_64: m = 64'hffff_ffff_ffff_ffff;
         default:  m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: src/vb128_decode.sv
`default_nettype none

module vb128_decode (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire vb128_pkg::req_word_type  req_data,
   input  wire vb128_pkg::width_mode_type width_mode,
   output logic                          res_valid,
   output vb128_pkg::rsp_word_type       res_data
);

   logic [vb128_pkg::ValueWidth-1:0] acc_ff, acc_in;
   logic [vb128_pkg::IndexWidth-1:0] byte_index_ff, byte_index_in;

   logic [6:0]                       shift_amt;
   logic                             in_range;
   logic [vb128_pkg::ValueWidth-1:0] payload;
   logic [vb128_pkg::ValueWidth-1:0] merged;
   logic                             cont;
   logic                             limit_hit;

   always_comb begin
      shift_amt = 7'(byte_index_ff) * vb128_pkg::BITS_PER_BYTE;
      in_range  = shift_amt < 7'd64;
      payload   = 64'(req_data.data_byte & vb128_pkg::PAYLOAD_MASK);
      merged    = acc_ff | (in_range ? (payload << shift_amt[5:0]) : '0);
      cont      = |(req_data.data_byte & vb128_pkg::CONT_BIT);
      limit_hit = ({1'b0, byte_index_ff} + 5'd1) >= vb128_pkg::byte_limit(width_mode);

      res_valid              = 1'b0;
      res_data.decoded_value = '0;
      res_data.status        = vb128_pkg::STATUS_OK;
      acc_in                 = acc_ff;
      byte_index_in          = byte_index_ff;

      if (accept) begin
         if (!cont) begin
            res_valid              = 1'b1;
            res_data.decoded_value = merged & vb128_pkg::width_mask(width_mode);
            acc_in                 = '0;
            byte_index_in          = '0;
         end else if (req_data.buffer_last || limit_hit) begin
            // stream ended or too many bytes while value still open
            res_valid       = 1'b1;
            res_data.status = vb128_pkg::STATUS_ERROR;
            acc_in          = '0;
            byte_index_in   = '0;
         end else begin
            acc_in        = merged;
            byte_index_in = byte_index_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         byte_index_ff <= '0;
      end else begin
         acc_ff        <= acc_in;
         byte_index_ff <= byte_index_in;
      end
   end

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= 4'd9)
      else $error("byte index beyond largest limit");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (byte_index_ff == '0) && (acc_ff == '0))
      else $error("state not cleared after result");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res_data.status == vb128_pkg::STATUS_ERROR)
         |-> res_data.decoded_value == '0)
      else $error("error result carries a value");

endmodule

`default_nettype wire

// File: src/vb128_out_buf.sv
`default_nettype none

module vb128_out_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    res_valid,
   input  wire vb128_pkg::rsp_word_type res_data,
   output logic                         full,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output vb128_pkg::rsp_word_type      rsp_data
);

   logic                    out_valid_ff, out_valid_in;
   vb128_pkg::rsp_word_type out_data_ff, out_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   vb128_pkg::rsp_word_type skid_data_ff, skid_data_in;
   logic                    out_free;

   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (out_free) begin
         if (skid_valid_ff) begin
            // input is stalled while skid holds a word
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res_data;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall && res_valid))
      else $error("skid filled without a stalled output");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !res_valid)
      else $error("new result while skid is full");

endmodule

`default_nettype wire

// File: src/varint_base128_decoder_core.sv
`default_nettype none

// unsigned base-128 varint decoder, one encoded byte per word
// a result word is registered on rsp_ (or in the skid while rsp_ stalls) from the
// byte that completes it; throughput: one byte accepted per cycle while req_stall
// is low; the decode and accumulate step is one shift-or and a counter update, and
// a two-word output buffer takes one more word in a stall; reset clears the accumulator
// and byte count, empties the output buffer and sets the result width to 64 bits
module varint_base128_decoder_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire vb128_pkg::req_word_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output vb128_pkg::rsp_word_type      rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_data
);

   vb128_pkg::width_mode_type width_mode_ff, width_mode_in;
   logic                      accept;
   logic                      res_valid;
   vb128_pkg::rsp_word_type   res_data;
   logic                      buf_full;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   always_comb begin
      width_mode_in = width_mode_ff;
      if (csr_valid && csr_ready) begin
         width_mode_in = vb128_pkg::width_mode_type'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff <= vb128_pkg::WIDTH_64;
      end else begin
         width_mode_ff <= width_mode_in;
      end
   end

   vb128_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .width_mode (width_mode_ff),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   vb128_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int ITEM_TARGET    = 600;
   localparam int PHASE_ITEMS    = 60;

   class varint_scoreboard;
      vb128_pkg::width_mode_type width_mode;
      logic [63:0]               accumulator;
      logic [3:0]                byte_index;
      vb128_pkg::rsp_word_type   expected_words[$];
      int                        mismatches;

      function new();
         width_mode  = vb128_pkg::WIDTH_64;
         accumulator = '0;
         byte_index  = '0;
         mismatches  = 0;
      endfunction

      function void set_width(vb128_pkg::width_mode_type m);
         width_mode = m;
      endfunction

      function int max_bytes(vb128_pkg::width_mode_type m);
         case (m)
            vb128_pkg::WIDTH_8:  return 2;
            vb128_pkg::WIDTH_16: return 3;
            vb128_pkg::WIDTH_32: return 5;
            default:             return 10;
         endcase
      endfunction

      // 1 << 64 is zero, so the 64-bit mode wraps to all ones
      function logic [63:0] value_mask(vb128_pkg::width_mode_type m);
         return (64'd1 << (8 << int'(m))) - 64'd1;
      endfunction

      function void decode_byte(vb128_pkg::req_word_type w);
         int                      shift;
         vb128_pkg::rsp_word_type word;
         shift = 7 * int'(byte_index);
         if (shift < 64) begin
            accumulator |= 64'(w.data_byte & vb128_pkg::PAYLOAD_MASK) << shift;
         end
         if ((w.data_byte & vb128_pkg::CONT_BIT) == 0) begin
            word.decoded_value = accumulator & value_mask(width_mode);
            word.status        = vb128_pkg::STATUS_OK;
            expected_words.push_back(word);
            accumulator = '0;
            byte_index  = '0;
         end else if (w.buffer_last || int'(byte_index) + 1 >= max_bytes(width_mode)) begin
            word.decoded_value = '0;
            word.status        = vb128_pkg::STATUS_ERROR;
            expected_words.push_back(word);
            accumulator = '0;
            byte_index  = '0;
         end else begin
            byte_index = byte_index + 4'd1;
         end
      endfunction

      function void check_word(vb128_pkg::rsp_word_type got);
         vb128_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none pending: value %h status %b",
                     $time, got.decoded_value, got.status);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got.decoded_value !== want.decoded_value) begin
            $display("%0t: decoded_value expected %h actual %h",
                     $time, want.decoded_value, got.decoded_value);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   vb128_pkg::req_word_type req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   vb128_pkg::rsp_word_type rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [1:0]              csr_data;

   varint_scoreboard sb = new();
   bit quiet;
   bit hold_request;
   int sent_items;

   varint_base128_decoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [6:0] pick_payload();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 7'h00;
      if (r == 1) return 7'h7f;
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lastf);
      int                      gap;
      vb128_pkg::req_word_type w;
      w.data_byte   = b;
      w.buffer_last = lastf;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.decode_byte(w);
      sent_items++;
   endtask

   // wait until every pending result is back, then let the last byte settle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_width(input vb128_pkg::width_mode_type m);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_width(m);
   endtask

   task automatic send_random_value();
      int r;
      int lim;
      int len;
      lim = sb.max_bytes(sb.width_mode);
      r   = $urandom_range(0, 99);
      if (r < 70) begin
         // well-formed, sometimes flagged as end of buffer
         len = $urandom_range(1, lim);
         for (int i = 0; i < len - 1; i++) send_byte({1'b1, pick_payload()}, 1'b0);
         send_byte({1'b0, pick_payload()}, $urandom_range(0, 3) == 0);
      end else if (r < 80) begin
         // too long: error at the limit, the tail starts a new value
         len = lim + $urandom_range(1, 3);
         for (int i = 0; i < len - 1; i++) send_byte({1'b1, pick_payload()}, 1'b0);
         send_byte({1'b0, pick_payload()}, 1'b0);
      end else if (r < 90) begin
         // buffer ends mid-value
         len = $urandom_range(1, lim);
         for (int i = 0; i < len - 1; i++) send_byte({1'b1, pick_payload()}, 1'b0);
         send_byte({1'b1, pick_payload()}, 1'b1);
      end else begin
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int run;
      rsp_stall = 1'b0;
      run = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            run = HOLD_CYCLES;
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) run = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("varint_base128_decoder_core test failed");
            $finish;
         end
      end
   end

   initial begin
      vb128_pkg::width_mode_type mode_order[4];
      vb128_pkg::width_mode_type m;
      int                        phase_start;
      mode_order   = '{vb128_pkg::WIDTH_8, vb128_pkg::WIDTH_64,
                       vb128_pkg::WIDTH_16, vb128_pkg::WIDTH_32};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      sent_items   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 64-bit width out of reset
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b0);
      // ten bytes, payload above bit 63 dropped
      repeat (9) send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h80, 1'b1);
      settle();

      write_width(vb128_pkg::WIDTH_8);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b0);
      // width changes while a value is half done
      send_byte(8'h81, 1'b0);
      settle();
      write_width(vb128_pkg::WIDTH_16);
      send_byte(8'h82, 1'b0);
      settle();
      write_width(vb128_pkg::WIDTH_8);
      send_byte(8'h83, 1'b0);
      settle();
      write_width(vb128_pkg::WIDTH_32);
      repeat (4) send_byte(8'hff, 1'b0);
      send_byte(8'h0f, 1'b0);
      settle();

      for (int phase = 0; sent_items < ITEM_TARGET; phase++) begin
         m = (phase < 4) ? mode_order[phase]
                         : vb128_pkg::width_mode_type'($urandom_range(0, 3));
         write_width(m);
         quiet = (phase % 5 == 2);
         // block fills while the receiver holds off
         if (phase == 3) hold_request = 1'b1;
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) send_random_value();
         settle();
      end

      quiet = 1'b0;
      settle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("varint_base128_decoder_core test passed");
      end else begin
         $display("varint_base128_decoder_core test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/vb128_pkg.sv
src/vb128_decode.sv
src/vb128_out_buf.sv
src/varint_base128_decoder_core.sv
tb/tb.sv
